// ===== sv/mqps_pkg.sv =====
// shared constants and types of the multi-queue priority scheduler
package mqps_pkg;

  localparam int NUM_QUEUES     = 5;
  localparam int QUEUE_CAPACITY = 16;
  localparam int PRIORITY_BITS  = 8;
  localparam int ID_BITS        = 16;

  localparam int FUNC_W   = 1;
  localparam int QIDX_W   = 3;
  localparam int PREQ_W   = 8;
  localparam int STATUS_W = 3;
  localparam int TASK_W   = 16;
  localparam int COUNT_W  = $clog2(QUEUE_CAPACITY + 1);

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NO_IDS   = 3'd4;

  typedef struct packed {
    logic [ID_BITS-1:0]       id;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } queue_op_t;

endpackage

// ===== sv/mqps_if.sv =====
// request and response channel interfaces of the scheduler
interface mqps_req_if;
  import mqps_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [QIDX_W-1:0]   queue_index;
  logic [PREQ_W-1:0]   priority_req;

  modport source (output valid, func, queue_index, priority_req, input ready);
  modport sink   (input valid, func, queue_index, priority_req, output ready);
endinterface

interface mqps_rsp_if;
  import mqps_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TASK_W-1:0]   task_id;

  modport source (output valid, status, task_id, input ready);
  modport sink   (input valid, status, task_id, output ready);
endinterface

// ===== sv/mqps_cell.sv =====
// one entry of a sorted queue chain
module mqps_cell (
  input  logic               clk_i,
  input  mqps_pkg::queue_op_t op_i,
  input  logic               valid_i,
  input  logic               left_gt_i,
  input  mqps_pkg::entry_t   left_entry_i,
  input  mqps_pkg::entry_t   right_entry_i,
  output logic               gt_o,
  output mqps_pkg::entry_t   entry_o
);
  import mqps_pkg::*;

  entry_t entry_q, entry_d;

  // new entry goes in front of this one (empty slots count as lower)
  assign gt_o = !valid_i || (op_i.new_entry.prio > entry_q.prio);

  always_comb begin
    entry_d = entry_q;
    priority if (op_i.rem) begin
      entry_d = right_entry_i;
    end else if (op_i.ins && left_gt_i) begin
      entry_d = left_entry_i;
    end else if (op_i.ins && gt_o) begin
      entry_d = op_i.new_entry;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== sv/mqps_queue.sv =====
// one priority queue as a sorted chain of cells with its fill count
module mqps_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mqps_pkg::queue_op_t           op_i,
  output logic [mqps_pkg::COUNT_W-1:0]  count_o,
  output logic [mqps_pkg::ID_BITS-1:0]  head_id_o
);
  import mqps_pkg::*;

  logic [COUNT_W-1:0]        count_q, count_d;
  entry_t                    cell_entry [QUEUE_CAPACITY];
  logic [QUEUE_CAPACITY-1:0] cell_gt;

  for (genvar i = 0; i < QUEUE_CAPACITY; i++) begin : g_cell
    entry_t left_entry, right_entry;
    logic   left_gt;

    if (i == 0) begin : g_head
      assign left_gt    = 1'b0;
      assign left_entry = cell_entry[i];
    end else begin : g_mid
      assign left_gt    = cell_gt[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == QUEUE_CAPACITY - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_body
      assign right_entry = cell_entry[i+1];
    end

    mqps_cell u_cell (
      .clk_i         (clk_i),
      .op_i          (op_i),
      .valid_i       (COUNT_W'(i) < count_q),
      .left_gt_i     (left_gt),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .gt_o          (cell_gt[i]),
      .entry_o       (cell_entry[i])
    );
  end

  always_comb begin
    count_d = count_q;
    priority if (op_i.rem) begin
      count_d = count_q - COUNT_W'(1);
    end else if (op_i.ins) begin
      count_d = count_q + COUNT_W'(1);
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o   = count_q;
  assign head_id_o = cell_entry[0].id;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_W'(QUEUE_CAPACITY))
    else $error("queue count above capacity");

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i.ins |-> count_q != COUNT_W'(QUEUE_CAPACITY))
    else $error("insert into a full queue");

  a_head_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= COUNT_W'(2) |->
      (cell_entry[0].prio > cell_entry[1].prio) ||
      (cell_entry[0].prio == cell_entry[1].prio && cell_entry[0].id < cell_entry[1].id))
    else $error("queue head out of order");

endmodule

// ===== sv/multi_queue_priority_scheduler.sv =====
// top level of the multi-queue priority scheduler
//
//  channel  dir  payload                           transfer
//  req_i    in   func, queue_index, priority_req   valid & ready
//  rsp_o    out  status, task_id                   valid & ready
//
//  each item first has its request registered, then updates the selected
//  cell chain and loads the response register
//  the next request is taken once the registered one has moved on
//  a stalled response holds the pending request in its register
//  reset empties every queue and sets the next job number to one
module multi_queue_priority_scheduler (
  input  logic clk_i,
  input  logic rst_ni,
  mqps_req_if.sink   req_i,
  mqps_rsp_if.source rsp_o
);
  import mqps_pkg::*;

  logic                     req_valid_q;
  logic [FUNC_W-1:0]        req_func_q;
  logic [QIDX_W-1:0]        req_qidx_q;
  logic [PRIORITY_BITS-1:0] req_prio_q;

  logic                 rsp_valid_q;
  logic [STATUS_W-1:0]  rsp_status_q, rsp_status_d;
  logic [TASK_W-1:0]    rsp_task_q, rsp_task_d;
  logic [ID_BITS-1:0]   next_id_q;

  logic                 req_xfer, proceed;
  logic                 qsel_ok, no_ids, ins_ok, rem_ok;
  logic [COUNT_W-1:0]   count_sel;
  logic [ID_BITS-1:0]   head_sel;

  logic [COUNT_W-1:0]   q_count [NUM_QUEUES];
  logic [ID_BITS-1:0]   q_head  [NUM_QUEUES];
  queue_op_t            q_op    [NUM_QUEUES];

  assign req_i.ready = !req_valid_q;
  assign req_xfer    = req_i.valid && req_i.ready;
  assign proceed     = req_valid_q && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    count_sel = '0;
    head_sel  = '0;
    for (int q = 0; q < NUM_QUEUES; q++) begin
      if (int'(req_qidx_q) == q) begin
        count_sel = q_count[q];
        head_sel  = q_head[q];
      end
    end
  end

  assign qsel_ok = int'(req_qidx_q) < NUM_QUEUES;
  assign no_ids  = &next_id_q;
  assign ins_ok  = (req_func_q == FUNC_INSERT) && !no_ids && qsel_ok
                   && (count_sel != COUNT_W'(QUEUE_CAPACITY));
  assign rem_ok  = (req_func_q == FUNC_REMOVE) && qsel_ok && (count_sel != '0);

  for (genvar q = 0; q < NUM_QUEUES; q++) begin : g_queue
    logic hit;
    assign hit = proceed && (int'(req_qidx_q) == q);
    assign q_op[q].ins            = hit && ins_ok;
    assign q_op[q].rem            = hit && rem_ok;
    assign q_op[q].new_entry.id   = next_id_q;
    assign q_op[q].new_entry.prio = req_prio_q;

    mqps_queue u_queue (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .op_i      (q_op[q]),
      .count_o   (q_count[q]),
      .head_id_o (q_head[q])
    );
  end

  always_comb begin
    rsp_status_d = ST_EMPTY;
    rsp_task_d   = '0;
    priority if (req_func_q == FUNC_REMOVE) begin
      if (rem_ok) begin
        rsp_status_d = ST_REMOVED;
        rsp_task_d   = TASK_W'(head_sel);
      end
    end else if (no_ids) begin
      rsp_status_d = ST_NO_IDS;
    end else if (!ins_ok) begin
      rsp_status_d = ST_FULL;
    end else begin
      rsp_status_d = ST_INSERTED;
      rsp_task_d   = TASK_W'(next_id_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
      next_id_q   <= ID_BITS'(1);
    end else begin
      if (req_xfer) begin
        req_valid_q <= 1'b1;
      end else if (proceed) begin
        req_valid_q <= 1'b0;
      end
      if (proceed) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (proceed && ins_ok) begin
        next_id_q <= next_id_q + ID_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      req_func_q <= req_i.func;
      req_qidx_q <= req_i.queue_index;
      req_prio_q <= PRIORITY_BITS'(req_i.priority_req);
    end
    if (proceed) begin
      rsp_status_q <= rsp_status_d;
      rsp_task_q   <= rsp_task_d;
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.status  = rsp_status_q;
  assign rsp_o.task_id = rsp_task_q;

  a_id_only_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(proceed && ins_ok) |=> $stable(next_id_q))
    else $error("job number moved without an insert");

  a_id_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (rsp_status_q == ST_INSERTED || rsp_status_q == ST_REMOVED)
      |-> rsp_task_q != '0)
    else $error("zero job number on success");

  a_id_zero_on_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && (rsp_status_q == ST_EMPTY || rsp_status_q == ST_FULL ||
                    rsp_status_q == ST_NO_IDS) |-> rsp_task_q == '0)
    else $error("job number on rejected item");

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ins_ok && rem_ok))
    else $error("insert and remove at once");

endmodule
